### rtl/core/ecpq_pkg.sv
// ----------------------------------------------------------------------------
// ecpq_pkg: shared types and constants for the event calendar
// Entry, cell command and channel word types used by the cell row and the
// top level.
// ----------------------------------------------------------------------------
package ecpq_pkg;

	localparam int DEPTH     = 16;
	localparam int TIME_BITS = 32;
	localparam int KIND_BITS = 2;
	localparam int CNT_BITS  = $clog2(DEPTH + 1);
	localparam int OCC_BITS  = 5;

	typedef enum logic {
		ACT_PUSH = 1'b0,
		ACT_POP  = 1'b1
	} action_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	// one calendar slot
	typedef struct packed {
		logic                 valid;
		logic [TIME_BITS-1:0] ev_time;
		logic [KIND_BITS-1:0] kind;
	} entry_t;

	// broadcast to every cell for one accepted word
	typedef struct packed {
		logic                 push;
		logic                 pop;
		logic [TIME_BITS-1:0] ev_time;
		logic [KIND_BITS-1:0] kind;
	} cell_cmd_t;

	typedef struct packed {
		logic        action;
		logic [31:0] event_time;
		logic [1:0]  event_kind;
	} in_word_t;

	typedef struct packed {
		logic [31:0] out_time;
		logic [1:0]  out_kind;
		logic [1:0]  status;
		logic [4:0]  occupancy;
	} out_word_t;

endpackage

### rtl/core/event_calendar_priority_queue.sv
// ----------------------------------------------------------------------------
// event_calendar_priority_queue: time-ordered event calendar
// Bounded priority queue of (time, kind) entries built as a row of cells.
// ----------------------------------------------------------------------------
// Usage:
//   in_valid/in_ready carry one input word: a push (action 0) with
//   event_time and event_kind, or a pop (action 1). out_valid/out_ready
//   carry one result word per input word: the popped time and kind (zero
//   for pushes and failures), a status code and the occupancy after it.
//   A push lands behind every held entry of equal or earlier time, so
//   ties leave in arrival order. Pop on empty reports status 1; push into
//   a full calendar is dropped with status 2; neither changes the store.
//   The result word sits in an output register the cycle after the input
//   word is taken. Throughput is one word per cycle while out_ready is high;
//   every cell compares against the broadcast time and shifts in one step.
//   in_ready stays high while the output register is empty or being
//   drained, so a stalled receiver holds off input after one word waits.
//   Reset clears every cell, the count and the output register at once.
// ----------------------------------------------------------------------------
module event_calendar_priority_queue (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  ecpq_pkg::in_word_t   in_data,
	output logic                 out_valid,
	input  logic                 out_ready,
	output ecpq_pkg::out_word_t  out_data
);
	import ecpq_pkg::*;

	entry_t    cell_entry [DEPTH];
	logic      cell_after [DEPTH];
	cell_cmd_t cmd;

	logic                accept;
	logic                is_pop;
	logic                empty;
	logic                full;
	logic [CNT_BITS-1:0] count_q;
	logic [CNT_BITS-1:0] count_d;
	logic                out_valid_q;
	out_word_t           out_data_q;
	out_word_t           result;

	assign in_ready = !out_valid_q || out_ready;
	assign accept   = in_valid && in_ready;
	assign is_pop   = (in_data.action == ACT_POP);
	assign empty    = !cell_entry[0].valid;
	assign full     = cell_entry[DEPTH-1].valid;

	// broadcast the word to the row
	always_comb begin
		cmd.push    = accept && !is_pop && !full;
		cmd.pop     = accept && is_pop && !empty;
		cmd.ev_time = TIME_BITS'(in_data.event_time);
		cmd.kind    = in_data.event_kind;
	end

	// build the row
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		entry_t left_e;
		logic   left_a;
		entry_t right_e;
		if (i == 0) begin : g_head
			assign left_e = '0;
			assign left_a = 1'b1;
		end else begin : g_mid
			assign left_e = cell_entry[i-1];
			assign left_a = cell_after[i-1];
		end
		if (i == DEPTH - 1) begin : g_tail
			assign right_e = '0;
		end else begin : g_body
			assign right_e = cell_entry[i+1];
		end
		ecpq_cell u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.cmd         (cmd),
			.left_entry  (left_e),
			.left_after  (left_a),
			.right_entry (right_e),
			.entry       (cell_entry[i]),
			.after       (cell_after[i])
		);
	end

	// track occupancy
	always_comb begin
		count_d = count_q;
		if (cmd.push) begin
			count_d = count_q + CNT_BITS'(1);
		end else if (cmd.pop) begin
			count_d = count_q - CNT_BITS'(1);
		end
	end

	// form the result word
	always_comb begin
		result           = '0;
		result.occupancy = OCC_BITS'(count_d);
		if (is_pop) begin
			if (empty) begin
				result.status = ST_EMPTY;
			end else begin
				result.out_time = 32'(cell_entry[0].ev_time);
				result.out_kind = cell_entry[0].kind;
			end
		end else if (full) begin
			result.status = ST_FULL;
		end
	end

	// advance count and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
			out_data_q  <= '0;
		end else begin
			count_q <= count_d;
			if (accept) begin
				out_valid_q <= 1'b1;
				out_data_q  <= result;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule

### rtl/core/ecpq_cell.sv
// ----------------------------------------------------------------------------
// ecpq_cell: one slot of the sorted cell row
// Holds one entry; on a push it keeps, takes the new entry or takes its left
// neighbor's entry; on a pop it takes its right neighbor's entry.
// ----------------------------------------------------------------------------
module ecpq_cell (
	input  logic               clk,
	input  logic               arst_n,
	input  ecpq_pkg::cell_cmd_t cmd,
	input  ecpq_pkg::entry_t   left_entry,
	input  logic               left_after,
	input  ecpq_pkg::entry_t   right_entry,
	output ecpq_pkg::entry_t   entry,
	output logic               after
);
	import ecpq_pkg::*;

	entry_t entry_q;
	entry_t entry_d;

	// new entry belongs behind this one (equal times keep arrival order)
	assign after = entry_q.valid && (entry_q.ev_time <= cmd.ev_time);

	// pick next contents
	always_comb begin
		entry_d = entry_q;
		if (cmd.push) begin
			if (!after) begin
				if (left_after) begin
					entry_d.valid   = 1'b1;
					entry_d.ev_time = cmd.ev_time;
					entry_d.kind    = cmd.kind;
				end else begin
					entry_d = left_entry;
				end
			end
		end else if (cmd.pop) begin
			entry_d = right_entry;
		end
	end

	// hold the slot
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_q <= '0;
		end else begin
			entry_q <= entry_d;
		end
	end

	assign entry = entry_q;

endmodule

### tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench: self-checking bench for event_calendar_priority_queue
// Drives push and pop words through the valid/ready input channel, keeps a
// shadow calendar in time order to work out each result word, and compares
// every result word field by field as it drains. Covers corner cases, a
// fill past capacity, a long random mix with idling on both sides, a
// back-to-back stretch, a receiver hold-off and a sender pause.
// ----------------------------------------------------------------------------
module testbench;
	import ecpq_pkg::*;

	localparam int CYCLE_LIMIT  = 200000;
	localparam int DRAIN_LIMIT  = 10000;
	localparam int IDLE_PERCENT = 26;
	localparam int MAX_REPORTS  = 50;

	logic      clk;
	logic      arst_n;
	logic      in_valid;
	logic      in_ready;
	in_word_t  in_data;
	logic      out_valid;
	logic      out_ready;
	out_word_t out_data;

	// shadow calendar, slot 0 is the head
	logic [TIME_BITS-1:0] cal_time [DEPTH];
	logic [KIND_BITS-1:0] cal_kind [DEPTH];
	int                   cal_count;

	out_word_t due_results[$];
	int        mismatch_count;
	int        cycle_count;
	int        rx_hold_cycles;
	bit        rx_no_idle;
	bit        tx_no_idle;

	event_calendar_priority_queue u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data)
	);

	// free-running clock
	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// count cycles and stop a hung run
	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("FAILURE");
		$finish;
	end

	task automatic report_mismatch(input string msg);
		if (mismatch_count < MAX_REPORTS)
			$display("ERROR cycle %0d: %s", cycle_count, msg);
		mismatch_count++;
	endtask

	// apply one word to the shadow calendar and return its result word
	function automatic out_word_t calendar_step(input in_word_t w);
		out_word_t r;
		int        pos;
		r = '0;
		if (action_t'(w.action) == ACT_PUSH) begin
			if (cal_count >= DEPTH) begin
				r.status = ST_FULL;
			end else begin
				// land behind every entry of equal or earlier time
				pos = 0;
				while (pos < cal_count && cal_time[pos] <= w.event_time)
					pos++;
				for (int i = cal_count; i > pos; i--) begin
					cal_time[i] = cal_time[i-1];
					cal_kind[i] = cal_kind[i-1];
				end
				cal_time[pos] = w.event_time;
				cal_kind[pos] = w.event_kind;
				cal_count++;
			end
		end else begin
			if (cal_count == 0) begin
				r.status = ST_EMPTY;
			end else begin
				r.out_time = cal_time[0];
				r.out_kind = cal_kind[0];
				for (int i = 1; i < cal_count; i++) begin
					cal_time[i-1] = cal_time[i];
					cal_kind[i-1] = cal_kind[i];
				end
				cal_count--;
				cal_time[cal_count] = '0;
				cal_kind[cal_count] = '0;
			end
		end
		r.occupancy = OCC_BITS'(cal_count);
		return r;
	endfunction

	// offer one word, hold it until taken, then log its expected result
	task automatic send_word(input in_word_t w);
		if (!tx_no_idle) begin
			while ($urandom_range(99) < IDLE_PERCENT) begin
				in_valid <= 1'b0;
				@(posedge clk);
			end
		end
		in_valid <= 1'b1;
		in_data  <= w;
		do
			@(posedge clk);
		while (!in_ready);
		due_results.push_back(calendar_step(w));
	endtask

	function automatic in_word_t push_word(input logic [31:0] t, input logic [1:0] k);
		in_word_t w;
		w.action     = ACT_PUSH;
		w.event_time = t;
		w.event_kind = k;
		return w;
	endfunction

	// pop with random stray payload, which the block must ignore
	function automatic in_word_t pop_word();
		in_word_t w;
		w.action     = ACT_POP;
		w.event_time = $urandom;
		w.event_kind = 2'($urandom_range(3));
		return w;
	endfunction

	// pick a time: narrow range for ties, extremes, or full range
	function automatic logic [31:0] pick_time();
		int sel;
		sel = $urandom_range(99);
		if (sel < 40)
			return $urandom_range(31);
		else if (sel < 50)
			case ($urandom_range(3))
				0: return 32'h0000_0000;
				1: return 32'hFFFF_FFFF;
				2: return 32'h7FFF_FFFF;
				default: return 32'h8000_0000;
			endcase
		else
			return $urandom;
	endfunction

	function automatic in_word_t random_word(input int push_percent);
		if ($urandom_range(99) < push_percent)
			return push_word(pick_time(), 2'($urandom_range(3)));
		return pop_word();
	endfunction

	// check each result word against the oldest expectation
	initial begin
		out_word_t want;
		out_ready = 1'b0;
		forever begin
			@(posedge clk);
			if (out_valid && out_ready) begin
				if (due_results.size() == 0) begin
					report_mismatch("result word with none expected");
				end else begin
					want = due_results.pop_front();
					if (out_data.out_time !== want.out_time)
						report_mismatch($sformatf("out_time %h, want %h",
							out_data.out_time, want.out_time));
					if (out_data.out_kind !== want.out_kind)
						report_mismatch($sformatf("out_kind %0d, want %0d",
							out_data.out_kind, want.out_kind));
					if (out_data.status !== want.status)
						report_mismatch($sformatf("status %0d, want %0d",
							out_data.status, want.status));
					if (out_data.occupancy !== want.occupancy)
						report_mismatch($sformatf("occupancy %0d, want %0d",
							out_data.occupancy, want.occupancy));
				end
			end
			// hold off, run flat out, or stall at random
			if (rx_hold_cycles > 0) begin
				rx_hold_cycles--;
				out_ready <= 1'b0;
			end else if (rx_no_idle) begin
				out_ready <= 1'b1;
			end else begin
				out_ready <= ($urandom_range(99) >= IDLE_PERCENT);
			end
		end
	end

	// empty pop, extremes, ties in arrival order, last-entry pop
	task automatic test_corner_cases();
		send_word(pop_word());
		send_word(push_word(32'hFFFF_FFFF, 2'd3));
		send_word(push_word(32'h0000_0000, 2'd0));
		send_word(push_word(32'd5, 2'd1));
		send_word(push_word(32'd5, 2'd2));
		send_word(push_word(32'd5, 2'd3));
		send_word(push_word(32'hFFFF_FFFF, 2'd1));
		repeat (6)
			send_word(pop_word());
		send_word(pop_word());
		send_word(push_word(32'hAAAA_AAAA, 2'd2));
		send_word(push_word(32'h5555_5555, 2'd1));
		send_word(pop_word());
		send_word(pop_word());
	endtask

	// fill to capacity, overflow twice, drain past empty
	task automatic test_fill_and_overflow();
		repeat (DEPTH)
			send_word(push_word(pick_time(), 2'($urandom_range(3))));
		send_word(push_word(32'd0, 2'd3));
		send_word(push_word(32'hFFFF_FFFF, 2'd0));
		repeat (DEPTH + 1)
			send_word(pop_word());
	endtask

	// swing occupancy between empty and full with biased phases
	task automatic test_random_mix(input int n_words);
		int sent;
		int seg_len;
		int push_percent;
		sent = 0;
		while (sent < n_words) begin
			seg_len = $urandom_range(20, 60);
			case ($urandom_range(2))
				0: push_percent = 85;
				1: push_percent = 50;
				default: push_percent = 15;
			endcase
			for (int i = 0; i < seg_len && sent < n_words; i++) begin
				send_word(random_word(push_percent));
				sent++;
			end
		end
	endtask

	// run both sides with no idling at all
	task automatic test_back_to_back();
		tx_no_idle = 1'b1;
		rx_no_idle = 1'b1;
		test_random_mix(200);
		tx_no_idle = 1'b0;
		rx_no_idle = 1'b0;
	endtask

	// stall the receiver while words keep coming, so input backs up
	task automatic test_receiver_hold();
		tx_no_idle     = 1'b1;
		rx_hold_cycles = 60;
		test_random_mix(40);
		tx_no_idle = 1'b0;
	endtask

	// pause the sender until every result has drained, then resume
	task automatic test_sender_pause();
		test_random_mix(20);
		in_valid <= 1'b0;
		while (due_results.size() != 0)
			@(posedge clk);
		test_random_mix(20);
	endtask

	initial begin
		int drain_cycles;
		arst_n         = 1'b0;
		in_valid       = 1'b0;
		in_data        = '0;
		cal_count      = 0;
		mismatch_count = 0;
		rx_hold_cycles = 0;
		rx_no_idle     = 1'b0;
		tx_no_idle     = 1'b0;
		for (int i = 0; i < DEPTH; i++) begin
			cal_time[i] = '0;
			cal_kind[i] = '0;
		end
		repeat (6)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_corner_cases();
		test_fill_and_overflow();
		test_random_mix(1100);
		test_back_to_back();
		test_receiver_hold();
		test_sender_pause();
		in_valid <= 1'b0;

		// wait for the last results, then keep watching for strays
		drain_cycles = 0;
		while (due_results.size() != 0 && drain_cycles < DRAIN_LIMIT) begin
			@(posedge clk);
			drain_cycles++;
		end
		repeat (5)
			@(posedge clk);
		if (due_results.size() != 0)
			report_mismatch($sformatf("%0d result words never arrived",
				due_results.size()));

		if (mismatch_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
